// ----- sv/ucdw_pkg.sv -----
// Package for the configuration-descriptor walker: codes, sizes and the result bundle type.
`timescale 1ns / 1ps
`default_nettype none

package ucdw_pkg;

	// Default sizes
	localparam int MAX_IFACES_DEF = 4;
	localparam int MAX_EPS_DEF    = 4;
	localparam int BUF_BYTES_DEF  = 256;

	// Register reset value and record storage depth
	localparam logic [8:0] TOTAL_LENGTH_RST = 9'd256;
	localparam int         REC_KEEP         = 9;

	// Descriptor type and class codes
	localparam logic [7:0] TYPE_CONFIG = 8'h02;
	localparam logic [7:0] TYPE_IFACE  = 8'h04;
	localparam logic [7:0] TYPE_EP     = 8'h05;
	localparam logic [7:0] TYPE_HID    = 8'h21;
	localparam logic [7:0] CLASS_HID   = 8'h03;

	// Minimum record lengths per type
	localparam logic [7:0] LEN_MIN_FULL = 8'd9;
	localparam logic [7:0] LEN_MIN_EP   = 8'd7;

	// Result kinds
	typedef enum logic [2:0] {
		KIND_CONFIG  = 3'd0,
		KIND_IFACE   = 3'd1,
		KIND_EP      = 3'd2,
		KIND_HID     = 3'd3,
		KIND_IGNORED = 3'd4,
		KIND_HALTED  = 3'd5,
		KIND_SUMMARY = 3'd6
	} kind_t;

	// Everything one byte produces: an optional record result and an optional summary
	typedef struct packed {
		logic        has_rec;
		kind_t       kind;
		logic [1:0]  iface_slot;
		logic [1:0]  ep_slot;
		logic [15:0] field_a;
		logic [7:0]  class_or_attr;
		logic [7:0]  sub_or_interval;
		logic [7:0]  proto;
		logic [15:0] field_b;
		logic        has_sum;
		logic [7:0]  sum_total;
		logic [15:0] sum_size;
		logic        hid_seen;
		logic [7:0]  hid_iface_num;
		logic [7:0]  hid_in_endpoint;
	} bundle_t;

endpackage

`default_nettype wire

// ----- sv/usb_config_descriptor_walker.sv -----
// Top level: byte-serial walker over a USB configuration descriptor buffer.
//
//  channel | handshake               | payload
//  --------+-------------------------+--------------------------------------------
//  in      | in_valid / in_ready     | data_byte, first, final_req
//  out     | out_valid / out_ready   | kind, slots, field_a/b, class.., hid_*, last
//  cfg     | cfg_wen (no wait)       | cfg_wdata -> total_length
//
// One byte is taken per cycle while in_ready is high, updating its record state in
// that same cycle; its results go to a two-entry result queue (registered out_valid).
// A byte that yields a record result and a summary needs two output transfers, so the
// queue drains one result per cycle while out_ready is high; in_ready drops only when full.
// Reset clears the walk state, the queue and sets total_length to 256.
// in_ready is a register output and does not depend on out_ready.
`timescale 1ns / 1ps
`default_nettype none

module usb_config_descriptor_walker
	import ucdw_pkg::*;
#(
	parameter int MAX_IFACES = MAX_IFACES_DEF,
	parameter int MAX_EPS    = MAX_EPS_DEF,
	parameter int BUF_BYTES  = BUF_BYTES_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	// configuration
	input  wire         cfg_wen,
	input  wire  [8:0]  cfg_wdata,
	// request input
	input  wire         in_valid,
	output logic        in_ready,
	input  wire  [7:0]  data_byte,
	input  wire         first,
	input  wire         final_req,
	// results
	output logic        out_valid,
	input  wire         out_ready,
	output logic [2:0]  kind,
	output logic [1:0]  iface_slot,
	output logic [1:0]  ep_slot,
	output logic [15:0] field_a,
	output logic [7:0]  class_or_attr,
	output logic [7:0]  sub_or_interval,
	output logic [7:0]  proto,
	output logic [15:0] field_b,
	output logic        hid_seen,
	output logic [7:0]  hid_iface_num,
	output logic [7:0]  hid_in_endpoint,
	output logic        last
);

	localparam int BL_W  = $clog2(BUF_BYTES + 1);
	localparam int CMP_W = (BL_W > 9) ? BL_W : 9;
	localparam int LB_W  = (BL_W > 8) ? BL_W : 8;
	localparam int IC_W  = $clog2(MAX_IFACES + 1);
	localparam int EC_W  = $clog2(MAX_EPS + 1);

	// Configuration register
	logic [8:0] total_length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_length_q <= TOTAL_LENGTH_RST;
		end else if (cfg_wen) begin
			total_length_q <= cfg_wdata;
		end
	end

	// Walk state
	logic [BL_W-1:0] bytes_left_q;
	logic [7:0]      pos_q, len_q, type_q;
	logic [7:0]      rb_q [REC_KEEP];
	logic [IC_W-1:0] ic_q;
	logic [EC_W-1:0] ec_q;
	logic [7:0]      last_ifnum_q;
	logic            hidf_q, halted_q;
	logic [7:0]      hidif_q, hidep_q, itot_q;
	logic [15:0]     rs_q;

	logic in_acc;
	assign in_acc = in_valid && in_ready;

	// Clamp of the buffer length
	logic [CMP_W-1:0] tl_ext;
	logic [BL_W-1:0]  bl_start;
	assign tl_ext   = CMP_W'(total_length_q);
	assign bl_start = (tl_ext > CMP_W'(BUF_BYTES)) ? BL_W'(BUF_BYTES) : BL_W'(tl_ext);

	// State seen by this byte (a first byte starts from a cleared walk)
	logic [BL_W-1:0] bl_b;
	logic [7:0]      pos_b, len_b, type_b, last_ifnum_b, hidif_b, hidep_b, itot_b;
	logic [IC_W-1:0] ic_b;
	logic [EC_W-1:0] ec_b;
	logic            hidf_b, halted_b;
	logic [15:0]     rs_b;

	always_comb begin
		bl_b         = first ? bl_start : bytes_left_q;
		pos_b        = first ? 8'd0 : pos_q;
		len_b        = first ? 8'd0 : len_q;
		type_b       = first ? 8'd0 : type_q;
		ic_b         = first ? '0 : ic_q;
		ec_b         = first ? '0 : ec_q;
		last_ifnum_b = first ? 8'd0 : last_ifnum_q;
		hidf_b       = first ? 1'b0 : hidf_q;
		hidif_b      = first ? 8'd0 : hidif_q;
		hidep_b      = first ? 8'd0 : hidep_q;
		rs_b         = first ? 16'd0 : rs_q;
		itot_b       = first ? 8'd0 : itot_q;
		halted_b     = first ? 1'b0 : halted_q;
	end

	// Record bytes as decode sees them: the current byte bypasses the store
	logic [7:0] r [REC_KEEP];
	logic [7:0] typ_eff;

	always_comb begin
		for (int i = 0; i < REC_KEEP; i++) begin
			r[i] = (pos_b == 8'(i)) ? data_byte : rb_q[i];
		end
		typ_eff = (pos_b == 8'd1) ? data_byte : type_b;
	end

	// Slot numbers on the fixed-width ports
	logic [IC_W+1:0] ic_ext, owner_ext;
	logic [EC_W+1:0] ec_ext;
	assign ic_ext    = {2'b00, ic_b};
	assign owner_ext = {2'b00, ic_b - IC_W'(1)};
	assign ec_ext    = {2'b00, ec_b};

	// Next walk state and this byte's record result
	logic [BL_W-1:0] bl_n;
	logic [7:0]      pos_n, len_n, type_n, last_ifnum_n, hidif_n, hidep_n, itot_n;
	logic [IC_W-1:0] ic_n;
	logic [EC_W-1:0] ec_n;
	logic            hidf_n, halted_n, rb_we;
	logic [15:0]     rs_n;
	logic [7:0]      pos_inc;
	logic            active;
	bundle_t         bnd;

	assign active = !halted_b && (bl_b != '0);

	always_comb begin
		bl_n = bl_b; pos_n = pos_b; len_n = len_b; type_n = type_b;
		ic_n = ic_b; ec_n = ec_b; last_ifnum_n = last_ifnum_b;
		hidf_n = hidf_b; hidif_n = hidif_b; hidep_n = hidep_b;
		rs_n = rs_b; itot_n = itot_b; halted_n = halted_b;
		rb_we   = 1'b0;
		pos_inc = pos_b + 8'd1;
		bnd     = '0;
		bnd.kind = KIND_IGNORED;

		if (active) begin
			if (pos_b == 8'd0) begin
				// length byte
				if (data_byte == 8'd0 || LB_W'(data_byte) > LB_W'(bl_b)) begin
					halted_n     = 1'b1;
					bnd.has_rec  = 1'b1;
					bnd.kind     = KIND_HALTED;
				end else begin
					len_n = data_byte;
					rb_we = 1'b1;
					bl_n  = bl_b - BL_W'(1);
					if (data_byte == 8'd1) begin
						bnd.has_rec = 1'b1;
					end else begin
						pos_n = 8'd1;
					end
				end
			end else begin
				// body byte
				rb_we = (pos_b < 8'(REC_KEEP));
				if (pos_b == 8'd1) begin
					type_n = data_byte;
				end
				bl_n  = bl_b - BL_W'(1);
				pos_n = pos_inc;
				if (pos_inc >= len_b) begin
					pos_n       = 8'd0;
					bnd.has_rec = 1'b1;
					// decode of the finished record
					if (typ_eff == TYPE_CONFIG && len_b >= LEN_MIN_FULL) begin
						itot_n      = r[4];
						bnd.kind    = KIND_CONFIG;
						bnd.field_a = {8'd0, r[4]};
					end else if (typ_eff == TYPE_IFACE && len_b >= LEN_MIN_FULL &&
					             ic_b < IC_W'(MAX_IFACES)) begin
						last_ifnum_n = r[2];
						if (r[5] == CLASS_HID) begin
							hidf_n  = 1'b1;
							hidif_n = r[2];
						end
						ic_n                = ic_b + IC_W'(1);
						ec_n                = '0;
						bnd.kind            = KIND_IFACE;
						bnd.iface_slot      = ic_ext[1:0];
						bnd.field_a         = {8'd0, r[2]};
						bnd.class_or_attr   = r[5];
						bnd.sub_or_interval = r[6];
						bnd.proto           = r[7];
						bnd.field_b         = {8'd0, r[4]};
					end else if (typ_eff == TYPE_EP && len_b >= LEN_MIN_EP &&
					             ic_b != '0 && ec_b < EC_W'(MAX_EPS)) begin
						// HID interrupt IN endpoint of the HID interface
						if (hidf_b && last_ifnum_b == hidif_b && r[2][7] &&
						    r[3][1:0] == 2'b11) begin
							hidep_n = r[2];
						end
						ec_n                = ec_b + EC_W'(1);
						bnd.kind            = KIND_EP;
						bnd.iface_slot      = owner_ext[1:0];
						bnd.ep_slot         = ec_ext[1:0];
						bnd.field_a         = {8'd0, r[2]};
						bnd.class_or_attr   = r[3];
						bnd.sub_or_interval = r[6];
						bnd.field_b         = {r[5], r[4]};
					end else if (typ_eff == TYPE_HID && len_b >= LEN_MIN_FULL && hidf_b) begin
						rs_n        = {r[8], r[7]};
						bnd.kind    = KIND_HID;
						bnd.field_a = {r[8], r[7]};
					end
				end
			end
		end

		bnd.has_sum         = final_req;
		bnd.sum_total       = itot_n;
		bnd.sum_size        = rs_n;
		bnd.hid_seen        = hidf_n;
		bnd.hid_iface_num   = hidif_n;
		bnd.hid_in_endpoint = hidep_n;
	end

	// Walk state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q <= '0;
			pos_q        <= '0;
			len_q        <= '0;
			type_q       <= '0;
			ic_q         <= '0;
			ec_q         <= '0;
			last_ifnum_q <= '0;
			hidf_q       <= 1'b0;
			hidif_q      <= '0;
			hidep_q      <= '0;
			rs_q         <= '0;
			itot_q       <= '0;
			halted_q     <= 1'b0;
		end else if (in_acc) begin
			bytes_left_q <= bl_n;
			pos_q        <= pos_n;
			len_q        <= len_n;
			type_q       <= type_n;
			ic_q         <= ic_n;
			ec_q         <= ec_n;
			last_ifnum_q <= last_ifnum_n;
			hidf_q       <= hidf_n;
			hidif_q      <= hidif_n;
			hidep_q      <= hidep_n;
			rs_q         <= rs_n;
			itot_q       <= itot_n;
			halted_q     <= halted_n;
		end
	end

	// Record byte store (payload, no reset)
	always_ff @(posedge clk) begin
		for (int i = 0; i < REC_KEEP; i++) begin
			if (in_acc && rb_we && pos_b == 8'(i)) begin
				rb_q[i] <= data_byte;
			end
		end
	end

	// Two-entry result queue; each entry holds up to two results
	bundle_t    fifo_q [2];
	logic       wr_ptr_q, rd_ptr_q, phase_q;
	logic [1:0] count_q;
	bundle_t    hd;
	logic       push, pop, out_acc, show_sum;

	assign hd       = fifo_q[rd_ptr_q];
	assign push     = in_acc && (bnd.has_rec || bnd.has_sum);
	assign show_sum = !hd.has_rec || phase_q;
	assign out_acc  = out_valid && out_ready;
	assign pop      = out_acc && last;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= bnd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q  <= 1'b0;
			rd_ptr_q  <= 1'b0;
			phase_q   <= 1'b0;
			count_q   <= 2'd0;
			in_ready  <= 1'b1;
			out_valid <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (out_acc) begin
				phase_q <= !pop;
			end
			count_q   <= count_q + {1'b0, push} - {1'b0, pop};
			in_ready  <= (count_q + {1'b0, push} - {1'b0, pop}) != 2'd2;
			out_valid <= (count_q + {1'b0, push} - {1'b0, pop}) != 2'd0;
		end
	end

	// Output selection
	always_comb begin
		kind            = show_sum ? KIND_SUMMARY : hd.kind;
		iface_slot      = show_sum ? 2'd0 : hd.iface_slot;
		ep_slot         = show_sum ? 2'd0 : hd.ep_slot;
		field_a         = show_sum ? {8'd0, hd.sum_total} : hd.field_a;
		class_or_attr   = show_sum ? 8'd0 : hd.class_or_attr;
		sub_or_interval = show_sum ? 8'd0 : hd.sub_or_interval;
		proto           = show_sum ? 8'd0 : hd.proto;
		field_b         = show_sum ? hd.sum_size : hd.field_b;
		hid_seen        = hd.hid_seen;
		hid_iface_num   = hd.hid_iface_num;
		hid_in_endpoint = hd.hid_in_endpoint;
		last            = show_sum || !hd.has_sum;
	end

	// Checks
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("result queue count out of range");

	a_sum_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_SUMMARY |-> last)
		else $error("summary result not marked last");

	a_second_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid && kind == KIND_SUMMARY)
		else $error("second result of a request missing");

	a_halt_pos: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |-> pos_q == 8'd0)
		else $error("walk halted inside a record");

	a_pos_len: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q != 8'd0 |-> pos_q < len_q)
		else $error("record position past record length");

endmodule

`default_nettype wire
